[rtl/core/ptt_pkg.sv]
`timescale 1ns / 1ps
package ptt_pkg;
  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W = 3;
  localparam int HINT_W = 4;

  typedef enum logic [3:0] {
    OP_CREATE = 4'd0, OP_PAUSE = 4'd1, OP_RESUME = 4'd2, OP_QUERY = 4'd3,
    OP_SET_COUNT = 4'd4, OP_SET_INTERVAL = 4'd5, OP_STOP_FIRE = 4'd6,
    OP_CANCEL = 4'd7, OP_TICK = 4'd8
  } opcode_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_UNUSED = 2'd2;

  localparam logic [0:0] REG_FOREVER = 1'b0;

  typedef struct packed {
    logic [1:0] status;
    logic fired;
    logic [2:0] result_slot;
    logic is_running;
    logic [15:0] count_now;
    logic [31:0] interval_now;
    logic last;
  } result_t;

  typedef struct packed {
    logic [3:0] opcode;
    logic [2:0] slot_id;
    logic [31:0] interval_value;
    logic [15:0] count_value;
    logic [31:0] tick_ms;
  } item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item
    logic do_single;  // execute non-tick op, build result
    logic scan_init;  // start scan
    logic scan_step;  // process one slot of the scan
    logic close;      // build closing result
    logic emit;       // load out register
    logic out_take;   // output transfer done
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic scan_done;
    logic scan_fire;
    logic out_full;
  } sts_t;
endpackage

[rtl/core/ptt_if.sv]
`timescale 1ns / 1ps
interface ptt_in_if;
  logic valid;
  logic ready;
  ptt_pkg::item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface ptt_out_if;
  logic valid;
  logic ready;
  ptt_pkg::result_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[rtl/core/periodic_task_timer_table.sv]
`timescale 1ns / 1ps
// A non-tick item is captured in the idle state; its result is loaded into the output
// register in the execute state once that register is free or being read. No new item
// is accepted until then. A tick walks all slots one at a time through the single shared
// elapsed-time adder in the datapath, emitting each fire result and a closing result.
// Reset (rst, synchronous): all slots free, free hint slot 0 valid, forever code 65535.
module periodic_task_timer_table (
  input  logic        clk,
  input  logic        rst,
  ptt_in_if.sink      in_ch,
  ptt_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ptt_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic [15:0] forever_code;
  logic reg_hit;

  // Only register 0 exists; decode on the word index.
  assign reg_hit = (paddr[1:0] == {REG_FOREVER, 1'b0});
  assign pready = 1'b1;
  assign prdata = reg_hit ? {16'd0, forever_code} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      forever_code <= 16'hFFFF;
    end else if (psel && penable && pwrite && reg_hit) begin
      forever_code <= pwdata[15:0];
    end
  end

  // Sequencer: hold each item until all its results are loaded into the output register.
  ptt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_ready(out_ch.ready), .sts(sts), .ctl(ctl)
  );

  // Slot table, free hint, scan pointer and output register.
  ptt_dp u_dp (
    .clk(clk), .rst(rst), .in_data(in_ch.data), .forever_code(forever_code),
    .ctl(ctl), .sts(sts), .out_valid(out_ch.valid), .out_data(out_ch.data)
  );
endmodule

[rtl/core/ptt_ctrl.sv]
`timescale 1ns / 1ps
module ptt_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_ready,
  input  ptt_pkg::sts_t sts,
  output ptt_pkg::ctl_t ctl
);
  import ptt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_EXEC = 5'b00010, S_SCAN = 5'b00100,
    S_FIREW = 5'b01000, S_CLOSE = 5'b10000
  } state_t;

  state_t state, state_next;
  logic take;

  assign take = !sts.out_full || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctl = '0;
    ctl.out_take = sts.out_full && out_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_tick) begin
          ctl.scan_init = 1'b1;
          state_next = S_SCAN;
        end else if (take) begin
          ctl.do_single = 1'b1;
          ctl.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_next = S_CLOSE;
        end else if (sts.scan_fire) begin
          state_next = S_FIREW;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      S_FIREW: begin
        if (take) begin
          ctl.scan_step = 1'b1;
          ctl.emit = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_CLOSE: begin
        if (take) begin
          ctl.close = 1'b1;
          ctl.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

[rtl/core/ptt_dp.sv]
`timescale 1ns / 1ps
module ptt_dp (
  input  logic clk,
  input  logic rst,
  input  ptt_pkg::item_t in_data,
  input  logic [15:0] forever_code,
  input  ptt_pkg::ctl_t ctl,
  output ptt_pkg::sts_t sts,
  output logic out_valid,
  output ptt_pkg::result_t out_data
);
  import ptt_pkg::*;

  item_t item;
  logic [SLOT_COUNT-1:0] used, running, forever_f;
  logic [15:0] count [SLOT_COUNT];
  logic [31:0] interval [SLOT_COUNT];
  logic [31:0] elapsed [SLOT_COUNT];
  logic [HINT_W-1:0] hint;
  logic hint_valid;
  logic [SLOT_W:0] scan_idx;
  logic [SLOT_W-1:0] sidx;
  logic [31:0] sum;
  logic fire_now;
  result_t res;
  logic [SLOT_W-1:0] hs, nxt;
  logic nxt_ok;
  logic [SLOT_COUNT-1:0] used_after;
  logic [15:0] cdec;

  assign sidx = scan_idx[SLOT_W-1:0];
  assign hs = hint[SLOT_W-1:0];
  assign sum = elapsed[sidx] + item.tick_ms;
  assign fire_now = used[sidx] && running[sidx] && (item.tick_ms != '0)
                    && (sum >= interval[sidx]);
  assign cdec = count[sidx] - 16'd1;

  assign sts.is_tick = (item.opcode == OP_TICK);
  assign sts.scan_done = scan_idx[SLOT_W];
  assign sts.scan_fire = fire_now;
  assign sts.out_full = out_valid;

  // round-robin search for next free slot after the one being claimed
  always_comb begin
    used_after = used;
    used_after[hs] = 1'b1;
    nxt = '0;
    nxt_ok = 1'b0;
    for (int k = SLOT_COUNT - 1; k >= 1; k--) begin
      if (!used_after[SLOT_W'((int'(hs) + k) % SLOT_COUNT)]) begin
        nxt = SLOT_W'((int'(hs) + k) % SLOT_COUNT);
        nxt_ok = 1'b1;
      end
    end
  end

  always_comb begin
    res = '0;
    res.last = 1'b1;
    if (ctl.scan_step) begin
      res.fired = 1'b1;
      res.result_slot = sidx;
      res.last = 1'b0;
    end else if (ctl.do_single) begin
      if (item.opcode == OP_CREATE) begin
        if (!hint_valid || (int'(hint) >= SLOT_COUNT)) begin
          res.status = ST_FULL;
        end else begin
          res.result_slot = hs;
        end
      end else if (item.opcode < OP_TICK) begin
        if (!used[item.slot_id]) begin
          res.status = ST_UNUSED;
        end else if (item.opcode == OP_QUERY) begin
          res.result_slot = item.slot_id;
          res.is_running = running[item.slot_id];
          res.count_now = count[item.slot_id];
          res.interval_now = interval[item.slot_id];
        end else if (item.opcode == OP_STOP_FIRE) begin
          res.fired = 1'b1;
          res.result_slot = item.slot_id;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      hint <= '0;
      hint_valid <= 1'b1;
      out_valid <= 1'b0;
      scan_idx <= '0;
    end else begin
      if (ctl.emit) out_valid <= 1'b1;
      else if (ctl.out_take) out_valid <= 1'b0;
      if (ctl.scan_init) scan_idx <= '0;
      if (ctl.do_single && item.opcode == OP_CREATE && hint_valid
          && int'(hint) < SLOT_COUNT) begin
        used[hs] <= 1'b1;
        hint <= HINT_W'(nxt);
        hint_valid <= nxt_ok;
      end
      if (ctl.do_single && used[item.slot_id] && (item.opcode == OP_STOP_FIRE
          || item.opcode == OP_CANCEL)) begin
        used[item.slot_id] <= 1'b0;
        hint <= HINT_W'(item.slot_id);
        hint_valid <= 1'b1;
      end
      if (ctl.scan_step) begin
        scan_idx <= scan_idx + 1'b1;
        if (fire_now && !forever_f[sidx] && cdec == '0) begin
          used[sidx] <= 1'b0;
          hint <= HINT_W'(sidx);
          hint_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) item <= in_data;
    if (ctl.emit) out_data <= res;
    if (ctl.do_single && item.opcode == OP_CREATE && hint_valid
        && int'(hint) < SLOT_COUNT) begin
      count[hs] <= item.count_value;
      interval[hs] <= item.interval_value;
      elapsed[hs] <= '0;
      running[hs] <= 1'b1;
      forever_f[hs] <= (item.count_value == forever_code);
    end
    if (ctl.do_single && used[item.slot_id]) begin
      case (item.opcode)
        OP_PAUSE: running[item.slot_id] <= 1'b0;
        OP_RESUME: running[item.slot_id] <= 1'b1;
        OP_SET_COUNT: count[item.slot_id] <= item.count_value;
        OP_SET_INTERVAL: interval[item.slot_id] <= item.interval_value;
        default: ;
      endcase
    end
    if (ctl.scan_step && used[sidx] && running[sidx] && item.tick_ms != '0) begin
      if (fire_now) begin
        elapsed[sidx] <= '0;
        if (!forever_f[sidx]) count[sidx] <= cdec;
      end else begin
        elapsed[sidx] <= sum;
      end
    end
  end
endmodule

[rtl/core/ptt_checker.sv]
`timescale 1ns / 1ps
module ptt_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic out_fired,
  input logic [1:0] out_status
);
  import ptt_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_nofire_nonlast: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> out_fired && out_status == ST_OK)
    else $error("bad tick fire result");
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_OK |-> out_last && !out_fired)
    else $error("bad error result");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("accepted twice");
endmodule

bind periodic_task_timer_table ptt_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_last(out_ch.data.last), .out_fired(out_ch.data.fired),
  .out_status(out_ch.data.status)
);
